FILE: sv/pts_pkg.sv
// Shared types, token kinds, byte codes and the keyword table for the token scanner.
// Used by pts_lexer, pts_queue, pascal_token_scanner and pts_checker. No dependencies.
package pts_pkg;

    localparam int KW_COUNT  = 30;
    localparam int KW_BYTES  = 9;   // longest keyword, "procedure"
    localparam int QDEPTH    = 4;

    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_IDENT   = 6'd1;
    localparam logic [5:0] K_NUMBER  = 6'd2;
    localparam logic [5:0] K_PLUS    = 6'd3;
    localparam logic [5:0] K_MINUS   = 6'd4;
    localparam logic [5:0] K_STAR    = 6'd5;
    localparam logic [5:0] K_SLASH   = 6'd6;
    localparam logic [5:0] K_COMMA   = 6'd7;
    localparam logic [5:0] K_SEMI    = 6'd8;
    localparam logic [5:0] K_ASSIGN  = 6'd9;
    localparam logic [5:0] K_COLON   = 6'd10;
    localparam logic [5:0] K_DOT     = 6'd11;
    localparam logic [5:0] K_LPAREN  = 6'd12;
    localparam logic [5:0] K_RPAREN  = 6'd13;
    localparam logic [5:0] K_LBRACK  = 6'd14;
    localparam logic [5:0] K_RBRACK  = 6'd15;
    localparam logic [5:0] K_CARET   = 6'd16;
    localparam logic [5:0] K_EQ      = 6'd17;
    localparam logic [5:0] K_GE      = 6'd18;
    localparam logic [5:0] K_GT      = 6'd19;
    localparam logic [5:0] K_LE      = 6'd20;
    localparam logic [5:0] K_LT      = 6'd21;
    localparam logic [5:0] K_KEYWORD0 = 6'd22;
    localparam logic [5:0] K_LAST    = 6'd51;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    localparam logic [7:0]  LEN_MAX  = 8'hFF;
    localparam logic [15:0] LINE_MAX = 16'hFFFF;
    localparam logic [15:0] FIRST_LINE_RESET = 16'd1;

    typedef logic [KW_BYTES-1:0][7:0] prefix_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [7:0]  length;
        logic [15:0] line;
        logic        run_end;
    } tok_t;

    typedef struct packed {
        logic        load;
        logic [15:0] value;
        logic [15:0] first_line;
    } cfg_t;

    // keyword text right-justified, zero-filled above
    function automatic logic [8*KW_BYTES-1:0] kw_text(input logic [4:0] k);
        logic [8*KW_BYTES-1:0] t;
        case (k)
            5'd0:  t = 72'("program");
            5'd1:  t = 72'("var");
            5'd2:  t = 72'("const");
            5'd3:  t = 72'("type");
            5'd4:  t = 72'("procedure");
            5'd5:  t = 72'("function");
            5'd6:  t = 72'("begin");
            5'd7:  t = 72'("end");
            5'd8:  t = 72'("if");
            5'd9:  t = 72'("then");
            5'd10: t = 72'("else");
            5'd11: t = 72'("while");
            5'd12: t = 72'("do");
            5'd13: t = 72'("for");
            5'd14: t = 72'("to");
            5'd15: t = 72'("downto");
            5'd16: t = 72'("repeat");
            5'd17: t = 72'("until");
            5'd18: t = 72'("case");
            5'd19: t = 72'("of");
            5'd20: t = 72'("with");
            5'd21: t = 72'("record");
            5'd22: t = 72'("array");
            5'd23: t = 72'("new");
            5'd24: t = 72'("dispose");
            5'd25: t = 72'("not");
            5'd26: t = 72'("div");
            5'd27: t = 72'("mod");
            5'd28: t = 72'("and");
            5'd29: t = 72'("or");
            default: t = '1;
        endcase
        return t;
    endfunction

    // kind of a finished word: keyword or identifier
    function automatic logic [5:0] word_kind(input logic [7:0] len, input prefix_t pfx);
        logic [8*KW_BYTES-1:0] w;
        logic [5:0] kind;
        w = '0;
        kind = K_IDENT;
        for (int i = 0; i < KW_BYTES; i++)
        begin
            if (8'(i) < len)
                w = {w[8*KW_BYTES-9:0], pfx[i]};
        end
        if (len <= 8'(KW_BYTES))
        begin
            for (int k = 0; k < KW_COUNT; k++)
            begin
                if (w == kw_text(5'(k)))
                    kind = K_KEYWORD0 + 6'(k);
            end
        end
        return kind;
    endfunction

endpackage

FILE: sv/pts_lexer.sv
// Scan state and per-byte token decode: produces up to three tokens per accepted byte.
// Depends on pts_pkg.
module pts_lexer #(
    parameter int POSITION_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          source_byte,
    input  logic                final_byte,
    input  pts_pkg::cfg_t       cfg,
    output pts_pkg::tok_t [2:0] toks,
    output logic [1:0]          tok_count
);

    typedef enum logic [2:0] {
        M_IDLE, M_WORD, M_NUM, M_COLON, M_LESS, M_GREATER, M_DOT
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [15:0]              line_reg, line_next;
    logic [7:0]               len_reg, len_next;
    pts_pkg::prefix_t         pfx_reg, pfx_next;

    logic        consumed;
    logic [1:0]  cnt;
    logic [7:0]  b;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= pts_pkg::CH_0 && c <= pts_pkg::CH_9;
    endfunction

    function automatic logic is_wordc(input logic [7:0] c);
        return (c >= pts_pkg::CH_LA && c <= pts_pkg::CH_LZ)
            || (c >= pts_pkg::CH_UA && c <= pts_pkg::CH_UZ)
            || is_digit(c) || c == pts_pkg::CH_UNDER;
    endfunction

    function automatic pts_pkg::tok_t mk(input logic [5:0] k, input logic [7:0] l,
                                         input logic [POSITION_BITS-1:0] s,
                                         input logic [15:0] ln);
        pts_pkg::tok_t t;
        t.kind    = k;
        t.start   = 24'(s);
        t.length  = l;
        t.line    = ln;
        t.run_end = 1'b0;
        return t;
    endfunction

    assign b = source_byte;

    always_comb
    begin
        toks       = '0;
        cnt        = 2'd0;
        consumed   = 1'b0;
        mode_next  = mode_reg;
        start_next = start_reg;
        line_next  = line_reg;
        len_next   = len_reg;
        pfx_next   = pfx_reg;
        pos_next   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

        // pending scan resolved by this byte
        unique case (mode_reg)
            M_WORD, M_NUM:
            begin
                if ((mode_reg == M_WORD) ? is_wordc(b) : is_digit(b))
                begin
                    consumed = 1'b1;
                    if (len_reg < 8'(pts_pkg::KW_BYTES))
                        pfx_next[len_reg[3:0]] = b;
                    if (len_reg != pts_pkg::LEN_MAX)
                        len_next = len_reg + 8'd1;
                end
                else
                begin
                    toks[cnt] = mk((mode_reg == M_WORD) ? pts_pkg::word_kind(len_reg, pfx_reg)
                                                        : pts_pkg::K_NUMBER,
                                   len_reg, start_reg, line_reg);
                    cnt = cnt + 2'd1;
                    mode_next = M_IDLE;
                end
            end
            M_COLON:
            begin
                if (b == pts_pkg::CH_EQ)
                begin
                    toks[cnt] = mk(pts_pkg::K_ASSIGN, 8'd2, start_reg, line_reg);
                    consumed = 1'b1;
                end
                else
                    toks[cnt] = mk(pts_pkg::K_COLON, 8'd1, start_reg, line_reg);
                cnt = cnt + 2'd1;
                mode_next = M_IDLE;
            end
            M_LESS:
            begin
                if (b == pts_pkg::CH_EQ)
                begin
                    toks[cnt] = mk(pts_pkg::K_LE, 8'd2, start_reg, line_reg);
                    cnt = cnt + 2'd1;
                    consumed = 1'b1;
                end
                else if (b == pts_pkg::CH_GT)
                begin
                    toks[0] = mk(pts_pkg::K_LT, 8'd1, start_reg, line_reg);
                    toks[1] = mk(pts_pkg::K_GT, 8'd1, start_reg, line_reg);
                    cnt = 2'd2;
                    consumed = 1'b1;
                end
                else
                begin
                    toks[cnt] = mk(pts_pkg::K_LT, 8'd1, start_reg, line_reg);
                    cnt = cnt + 2'd1;
                end
                mode_next = M_IDLE;
            end
            M_GREATER:
            begin
                if (b == pts_pkg::CH_EQ)
                begin
                    toks[cnt] = mk(pts_pkg::K_GE, 8'd2, start_reg, line_reg);
                    consumed = 1'b1;
                end
                else
                    toks[cnt] = mk(pts_pkg::K_GT, 8'd1, start_reg, line_reg);
                cnt = cnt + 2'd1;
                mode_next = M_IDLE;
            end
            M_DOT:
            begin
                if (b == pts_pkg::CH_DOT)
                begin
                    toks[cnt] = mk(pts_pkg::K_DOT, 8'd1, start_reg, line_reg);
                    cnt = cnt + 2'd1;
                    consumed = 1'b1;
                end
                mode_next = M_IDLE;
            end
            default: mode_next = M_IDLE;
        endcase

        // byte opens a new scan
        if (!consumed)
        begin
            start_next = pos_reg;
            mode_next  = M_IDLE;
            case (b)
                pts_pkg::CH_SPACE, pts_pkg::CH_CR, pts_pkg::CH_TAB: ;
                pts_pkg::CH_LF:
                    if (line_reg != pts_pkg::LINE_MAX)
                        line_next = line_reg + 16'd1;
                pts_pkg::CH_COLON:   mode_next = M_COLON;
                pts_pkg::CH_GT:      mode_next = M_GREATER;
                pts_pkg::CH_LT:      mode_next = M_LESS;
                pts_pkg::CH_PLUS, pts_pkg::CH_MINUS, pts_pkg::CH_STAR, pts_pkg::CH_SLASH,
                pts_pkg::CH_COMMA, pts_pkg::CH_SEMI, pts_pkg::CH_DOT, pts_pkg::CH_LPAREN,
                pts_pkg::CH_RPAREN, pts_pkg::CH_LBRACK, pts_pkg::CH_RBRACK,
                pts_pkg::CH_CARET, pts_pkg::CH_EQ:
                begin
                    case (b)
                        pts_pkg::CH_PLUS:   toks[cnt] = mk(pts_pkg::K_PLUS, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_MINUS:  toks[cnt] = mk(pts_pkg::K_MINUS, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_STAR:   toks[cnt] = mk(pts_pkg::K_STAR, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_SLASH:  toks[cnt] = mk(pts_pkg::K_SLASH, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_COMMA:  toks[cnt] = mk(pts_pkg::K_COMMA, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_SEMI:   toks[cnt] = mk(pts_pkg::K_SEMI, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_DOT:    toks[cnt] = mk(pts_pkg::K_DOT, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_LPAREN: toks[cnt] = mk(pts_pkg::K_LPAREN, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_RPAREN: toks[cnt] = mk(pts_pkg::K_RPAREN, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_LBRACK: toks[cnt] = mk(pts_pkg::K_LBRACK, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_RBRACK: toks[cnt] = mk(pts_pkg::K_RBRACK, 8'd1, pos_reg, line_reg);
                        pts_pkg::CH_CARET:  toks[cnt] = mk(pts_pkg::K_CARET, 8'd1, pos_reg, line_reg);
                        default:            toks[cnt] = mk(pts_pkg::K_EQ, 8'd1, pos_reg, line_reg);
                    endcase
                    cnt = cnt + 2'd1;
                    if (b == pts_pkg::CH_DOT)
                        mode_next = M_DOT;
                end
                default:
                begin
                    if (is_wordc(b))
                    begin
                        len_next    = 8'd1;
                        pfx_next[0] = b;
                        mode_next   = is_digit(b) ? M_NUM : M_WORD;
                    end
                    else
                    begin
                        // quotes and stray bytes: one-byte identifier
                        toks[cnt] = mk(pts_pkg::K_IDENT, 8'd1, pos_reg, line_reg);
                        cnt = cnt + 2'd1;
                    end
                end
            endcase
        end

        if (final_byte)
        begin
            unique case (mode_next)
                M_WORD:
                begin
                    toks[cnt] = mk(pts_pkg::word_kind(len_next, pfx_next), len_next,
                                   start_next, line_next);
                    cnt = cnt + 2'd1;
                end
                M_NUM:
                begin
                    toks[cnt] = mk(pts_pkg::K_NUMBER, len_next, start_next, line_next);
                    cnt = cnt + 2'd1;
                end
                M_COLON:
                begin
                    toks[cnt] = mk(pts_pkg::K_COLON, 8'd1, start_next, line_next);
                    cnt = cnt + 2'd1;
                end
                M_LESS:
                begin
                    toks[cnt] = mk(pts_pkg::K_LT, 8'd1, start_next, line_next);
                    cnt = cnt + 2'd1;
                end
                M_GREATER:
                begin
                    toks[cnt] = mk(pts_pkg::K_GT, 8'd1, start_next, line_next);
                    cnt = cnt + 2'd1;
                end
                default: ;
            endcase
            toks[cnt] = mk(pts_pkg::K_EOF, 8'd0, start_next, line_next);
            cnt = cnt + 2'd1;
            mode_next  = M_IDLE;
            pos_next   = '0;
            start_next = '0;
            line_next  = cfg.first_line;
            len_next   = 8'd0;
        end

        if (cnt != 2'd0)
            toks[cnt - 2'd1].run_end = 1'b1;
        tok_count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            line_reg  <= pts_pkg::FIRST_LINE_RESET;
            len_reg   <= 8'd0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            line_reg  <= line_next;
            len_reg   <= len_next;
        end
        else if (cfg.load && pos_reg == '0)
        begin
            line_reg <= cfg.value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            pfx_reg <= pfx_next;
    end

endmodule

FILE: sv/pts_queue.sv
// Result queue: up to three tokens in per cycle, one word out per cycle on pop.
// Depends on pts_pkg.
module pts_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_count,
    input  pts_pkg::tok_t [2:0] push_toks,
    input  logic                pop,
    output pts_pkg::tok_t       head,
    output logic                not_empty,
    output logic                room
);

    pts_pkg::tok_t [pts_pkg::QDEPTH-1:0] q_reg, q_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] cnt_kept;
    logic [2:0] rel;

    always_comb
    begin
        cnt_kept = cnt_reg - {2'b00, pop};
        q_next = q_reg;
        rel = 3'd0;
        if (pop)
        begin
            for (int j = 0; j < pts_pkg::QDEPTH - 1; j++)
                q_next[j] = q_reg[j + 1];
        end
        for (int j = 0; j < pts_pkg::QDEPTH; j++)
        begin
            rel = 3'(j) - cnt_kept;
            if (3'(j) >= cnt_kept && rel < {1'b0, push_count})
                q_next[j] = push_toks[rel[1:0]];
        end
        cnt_next = cnt_kept + {1'b0, push_count};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign head      = q_reg[0];
    assign not_empty = (cnt_reg != 3'd0);
    // room for a worst-case byte of three tokens
    assign room      = (cnt_reg <= 3'd1);

endmodule

FILE: sv/pascal_token_scanner.sv
// Top level of the Pascal token scanner: config register, lexer and result queue.
// Depends on pts_pkg, pts_lexer, pts_queue.
//
// Usage:
//   Input channel in_valid/in_ready carries one source byte per word plus
//   final_byte, set on the last byte of a source. Output channel
//   out_valid/out_ready carries one token per word: kind, start offset,
//   length, line and run_end (set on the last token a byte caused).
//   A byte is decoded in the cycle it is accepted; its tokens are registered
//   into the result queue and leave it in order, one per cycle while out_ready
//   is high; the scanner then keeps one byte per cycle while each byte gives
//   at most one token. Bytes giving two or three tokens hold the input while
//   the four-entry result queue drains (input taken while it holds at most
//   one token).
//   Receiver stall: tokens wait in the queue, input stops once it holds more than one token.
//   Reset: scan idle, position 0, line 1, first_line_number 1, queue empty.
//   Register first_line_number at address 0 over the APB port; writing it
//   before any byte of a source also sets the current line.
module pascal_token_scanner #(
    parameter int POSITION_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  source_byte,
    input  logic        final_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  token_kind,
    output logic [23:0] token_start,
    output logic [7:0]  token_length,
    output logic [15:0] line_number,
    output logic        run_end
);

    logic [15:0]         first_line_reg;
    logic                cfg_wr;
    pts_pkg::cfg_t       cfg;
    pts_pkg::tok_t [2:0] toks;
    logic [1:0]          tok_count;
    logic                take;
    pts_pkg::tok_t       head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, first_line_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_line_reg <= pts_pkg::FIRST_LINE_RESET;
        else if (cfg_wr)
            first_line_reg <= pwdata[15:0];
    end

    assign cfg.load       = cfg_wr;
    assign cfg.value      = pwdata[15:0];
    assign cfg.first_line = first_line_reg;

    assign take = in_valid && in_ready;

    pts_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .source_byte(source_byte),
        .final_byte (final_byte),
        .cfg        (cfg),
        .toks       (toks),
        .tok_count  (tok_count)
    );

    pts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_count(take ? tok_count : 2'd0),
        .push_toks (toks),
        .pop       (out_valid && out_ready),
        .head      (head),
        .not_empty (out_valid),
        .room      (in_ready)
    );

    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign line_number  = head.line;
    assign run_end      = head.run_end;

endmodule

FILE: sv/pts_checker.sv
// Port-level checks for the token scanner, bound to the top level.
// Depends on pts_pkg and pascal_token_scanner.
module pts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  token_kind,
    input logic [7:0]  token_length,
    input logic        run_end
);

    // a stalled output stays valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("token dropped while stalled");

    // end of file is always the last token of its byte
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == pts_pkg::K_EOF |-> run_end)
        else $error("eof token without run_end");

    a_eof_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == pts_pkg::K_EOF |-> token_length == 8'd0)
        else $error("eof token with nonzero length");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> token_kind <= pts_pkg::K_LAST)
        else $error("token kind out of range");

endmodule

bind pascal_token_scanner pts_checker u_pts_checker (.*);

FILE: bench/testbench.sv
// Self-checking bench for pascal_token_scanner: directed byte table, long word, random text.
// Tokens are predicted in-bench and checked in order. Depends on pts_pkg and the scanner RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ITEM_TARGET = 410;
    localparam int  CYCLE_LIMIT = 300000;
    localparam int  DRAIN_CYCLES = 8;
    localparam logic [2:0] ADDR_FIRST_LINE = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;
    localparam int  NO_KIND = -1;

    typedef enum logic [2:0] {
        S_IDLE, S_WORD, S_NUM, S_COLON, S_LESS, S_GREATER, S_DOT
    } scan_state_t;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        int         want;   // kind of the first token this byte gives, or NO_KIND
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  source_byte = '0;
    logic        final_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  token_kind;
    logic [23:0] token_start;
    logic [7:0]  token_length;
    logic [15:0] line_number;
    logic        run_end;

    pascal_token_scanner u_dut (.*);

    always #10 clk = ~clk;

    // scanner copy
    scan_state_t    mode;
    logic [23:0]    position, scan_origin;
    logic [15:0]    line_cnt, first_line;
    logic [7:0]     word_len;
    logic [7:0]     prefix [9];
    pts_pkg::tok_t  step_tokens [$];
    pts_pkg::tok_t  expected_tokens [$];

    string kw_words [30] = '{"program", "var", "const", "type", "procedure", "function",
        "begin", "end", "if", "then", "else", "while", "do", "for", "to", "downto",
        "repeat", "until", "case", "of", "with", "record", "array", "new", "dispose",
        "not", "div", "mod", "and", "or"};
    string op_texts [21] = '{":=", ":", "<>", "<=", ">=", "<", ">", "..", ".", "+", "-",
        "*", "/", ",", ";", "(", ")", "[", "]", "^", "="};

    int  errors = 0, items_sent = 0, tokens_seen = 0, sources_done = 0;
    int  cycles = 0;
    bit  calm = 1'b0;

    function automatic bit is_digit(logic [7:0] b);
        return b >= pts_pkg::CH_0 && b <= pts_pkg::CH_9;
    endfunction

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= pts_pkg::CH_LA && b <= pts_pkg::CH_LZ)
            || (b >= pts_pkg::CH_UA && b <= pts_pkg::CH_UZ);
    endfunction

    function automatic void add_token(logic [5:0] kind, logic [7:0] len);
        pts_pkg::tok_t t;
        if (step_tokens.size() >= 3)
            return;
        t.kind = kind;
        t.start = scan_origin;
        t.length = len;
        t.line = line_cnt;
        t.run_end = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void add_word_byte(logic [7:0] b);
        if (word_len < 9)
            prefix[word_len] = b;
        if (word_len != pts_pkg::LEN_MAX)
            word_len++;
    endfunction

    function automatic logic [5:0] classify_word();
        logic [5:0] kind;
        bit same;
        kind = pts_pkg::K_IDENT;
        if (word_len <= 9)
        begin
            for (int k = 0; k < 30; k++)
            begin
                same = kw_words[k].len() == word_len;
                for (int i = 0; same && i < word_len; i++)
                    if (kw_words[k][i] != prefix[i])
                        same = 0;
                if (same)
                    kind = pts_pkg::K_KEYWORD0 + 6'(k);
            end
        end
        return kind;
    endfunction

    function automatic void flush_scan();
        case (mode)
            S_WORD:    add_token(classify_word(), word_len);
            S_NUM:     add_token(pts_pkg::K_NUMBER, word_len);
            S_COLON:   add_token(pts_pkg::K_COLON, 8'd1);
            S_LESS:    add_token(pts_pkg::K_LT, 8'd1);
            S_GREATER: add_token(pts_pkg::K_GT, 8'd1);
            default: ;
        endcase
        mode = S_IDLE;
    endfunction

    function automatic void start_over();
        mode = S_IDLE;
        position = '0;
        scan_origin = '0;
        line_cnt = first_line;
        word_len = '0;
    endfunction

    function automatic void open_scan(logic [7:0] b);
        scan_origin = position;
        mode = S_IDLE;
        case (b)
            pts_pkg::CH_SPACE, pts_pkg::CH_CR, pts_pkg::CH_TAB: ;
            pts_pkg::CH_LF:     if (line_cnt != pts_pkg::LINE_MAX) line_cnt++;
            pts_pkg::CH_PLUS:   add_token(pts_pkg::K_PLUS, 8'd1);
            pts_pkg::CH_MINUS:  add_token(pts_pkg::K_MINUS, 8'd1);
            pts_pkg::CH_STAR:   add_token(pts_pkg::K_STAR, 8'd1);
            pts_pkg::CH_SLASH:  add_token(pts_pkg::K_SLASH, 8'd1);
            pts_pkg::CH_COMMA:  add_token(pts_pkg::K_COMMA, 8'd1);
            pts_pkg::CH_SEMI:   add_token(pts_pkg::K_SEMI, 8'd1);
            pts_pkg::CH_COLON:  mode = S_COLON;
            pts_pkg::CH_DOT:
            begin
                add_token(pts_pkg::K_DOT, 8'd1);
                mode = S_DOT;
            end
            pts_pkg::CH_LPAREN: add_token(pts_pkg::K_LPAREN, 8'd1);
            pts_pkg::CH_RPAREN: add_token(pts_pkg::K_RPAREN, 8'd1);
            pts_pkg::CH_LBRACK: add_token(pts_pkg::K_LBRACK, 8'd1);
            pts_pkg::CH_RBRACK: add_token(pts_pkg::K_RBRACK, 8'd1);
            pts_pkg::CH_CARET:  add_token(pts_pkg::K_CARET, 8'd1);
            pts_pkg::CH_EQ:     add_token(pts_pkg::K_EQ, 8'd1);
            pts_pkg::CH_GT:     mode = S_GREATER;
            pts_pkg::CH_LT:     mode = S_LESS;
            default:
            begin
                if (is_digit(b) || is_alpha(b) || b == pts_pkg::CH_UNDER)
                begin
                    word_len = '0;
                    add_word_byte(b);
                    mode = is_digit(b) ? S_NUM : S_WORD;
                end
                else
                    add_token(pts_pkg::K_IDENT, 8'd1);
            end
        endcase
    endfunction

    // predicts the tokens of one accepted byte into step_tokens
    function automatic void scan_byte(logic [7:0] b, logic fin);
        bit used;
        used = 0;
        step_tokens.delete();
        case (mode)
            S_WORD, S_NUM:
            begin
                if (mode == S_WORD ? (is_alpha(b) || is_digit(b) || b == pts_pkg::CH_UNDER)
                                   : is_digit(b))
                begin
                    add_word_byte(b);
                    used = 1;
                end
                else
                    flush_scan();
            end
            S_COLON:
            begin
                if (b == pts_pkg::CH_EQ)
                begin
                    add_token(pts_pkg::K_ASSIGN, 8'd2);
                    used = 1;
                end
                else
                    add_token(pts_pkg::K_COLON, 8'd1);
            end
            S_LESS:
            begin
                if (b == pts_pkg::CH_EQ)
                begin
                    add_token(pts_pkg::K_LE, 8'd2);
                    used = 1;
                end
                else if (b == pts_pkg::CH_GT)
                begin
                    add_token(pts_pkg::K_LT, 8'd1);
                    add_token(pts_pkg::K_GT, 8'd1);
                    used = 1;
                end
                else
                    add_token(pts_pkg::K_LT, 8'd1);
            end
            S_GREATER:
            begin
                if (b == pts_pkg::CH_EQ)
                begin
                    add_token(pts_pkg::K_GE, 8'd2);
                    used = 1;
                end
                else
                    add_token(pts_pkg::K_GT, 8'd1);
            end
            S_DOT:
            begin
                if (b == pts_pkg::CH_DOT)
                begin
                    add_token(pts_pkg::K_DOT, 8'd1);
                    used = 1;
                end
            end
            default: ;
        endcase
        // one-byte lookahead modes always end here
        if (mode != S_WORD && mode != S_NUM)
            mode = S_IDLE;
        if (!used)
            open_scan(b);
        if (position != '1)
            position++;
        if (fin)
        begin
            flush_scan();
            add_token(pts_pkg::K_EOF, 8'd0);
            start_over();
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].run_end = 1'b1;
    endfunction

    // one byte over the input channel; returns the first predicted kind
    task automatic send_byte(logic [7:0] b, logic fin, output int first_kind);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        source_byte <= b;
        final_byte <= fin;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        scan_byte(b, fin);
        first_kind = step_tokens.size() > 0 ? int'(step_tokens[0].kind) : NO_KIND;
        foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
        items_sent++;
        if (fin) sources_done++;
    endtask

    task automatic send_text(string s);
        int k;
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], $urandom_range(0, 59) == 0, k);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        while (expected_tokens.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_first_line(logic [15:0] value);
        idle_input();
        apb_access(1'b1, ADDR_FIRST_LINE, {16'd0, value});
        first_line = value;
        if (position == '0)
            line_cnt = value;
        apb_access(1'b0, ADDR_FIRST_LINE, '0);
        if (prdata[15:0] !== value)
        begin
            $display("%0t readback first_line_number: expected %0d, got %0d",
                     $time, value, prdata[15:0]);
            errors++;
        end
    endtask

    // random source text: mostly well-formed tokens, some noise
    task automatic random_text(int count);
        string s;
        int r, n;
        while (items_sent < count)
        begin
            r = $urandom_range(0, 99);
            s = "";
            if (r < 28)
            begin
                s = kw_words[$urandom_range(0, 29)];
                if ($urandom_range(0, 9) == 0)
                    s[0] = s[0] - 8'h20;
            end
            else if (r < 48)
            begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                begin
                    case ($urandom_range(0, 3))
                        0: s = {s, string'(8'($urandom_range(pts_pkg::CH_UA, pts_pkg::CH_UZ)))};
                        1: s = {s, string'(8'($urandom_range(pts_pkg::CH_0, pts_pkg::CH_9)))};
                        2: s = {s, "_"};
                        default:
                            s = {s, string'(8'($urandom_range(pts_pkg::CH_LA, pts_pkg::CH_LZ)))};
                    endcase
                end
            end
            else if (r < 60)
            begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range(pts_pkg::CH_0, pts_pkg::CH_9)))};
            end
            else if (r < 82)
                s = op_texts[$urandom_range(0, 20)];
            else if (r < 94)
                case ($urandom_range(0, 3))
                    0: s = "\n";
                    1: s = "\t";
                    2: s = "\r";
                    default: s = " ";
                endcase
            else
                s = string'(8'($urandom_range(0, 255)));
            send_text(s);
        end
    endtask

    row_t directed [] = '{
        '{8'h00, 1'b0, pts_pkg::K_IDENT},
        '{8'hFF, 1'b0, pts_pkg::K_IDENT},
        '{pts_pkg::CH_COLON, 1'b0, NO_KIND},
        '{pts_pkg::CH_EQ, 1'b0, pts_pkg::K_ASSIGN},
        '{pts_pkg::CH_LT, 1'b0, NO_KIND},
        '{pts_pkg::CH_GT, 1'b0, pts_pkg::K_LT},
        '{pts_pkg::CH_DOT, 1'b0, pts_pkg::K_DOT},
        '{pts_pkg::CH_DOT, 1'b0, pts_pkg::K_DOT},
        '{pts_pkg::CH_GT, 1'b0, NO_KIND},
        '{pts_pkg::CH_EQ, 1'b0, pts_pkg::K_GE},
        '{pts_pkg::CH_LF, 1'b0, NO_KIND},
        '{"d", 1'b0, NO_KIND},
        '{"o", 1'b0, NO_KIND},
        '{pts_pkg::CH_SPACE, 1'b0, pts_pkg::K_KEYWORD0 + 6'd12},
        '{"9", 1'b0, NO_KIND},
        '{pts_pkg::CH_UNDER, 1'b0, pts_pkg::K_NUMBER},
        '{"'", 1'b0, pts_pkg::K_IDENT},
        '{pts_pkg::CH_LT, 1'b0, NO_KIND},
        '{pts_pkg::CH_EQ, 1'b0, pts_pkg::K_LE},
        '{pts_pkg::CH_COLON, 1'b0, NO_KIND},
        '{"x", 1'b0, pts_pkg::K_COLON},
        '{pts_pkg::CH_GT, 1'b1, pts_pkg::K_IDENT},
        '{pts_pkg::CH_PLUS, 1'b1, pts_pkg::K_PLUS}
    };

    // output side: random stall per word, compare in order
    int stall_left = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (out_valid && out_ready)
        begin
            tokens_seen <= tokens_seen + 1;
            if (expected_tokens.size() == 0)
            begin
                $display("%0t unexpected token kind %0d start %0d", $time,
                         token_kind, token_start);
                errors <= errors + 1;
            end
            else
            begin
                if ({token_kind, token_start, token_length, line_number, run_end}
                    !== expected_tokens[0])
                begin
                    $display({"%0t token mismatch: expected kind %0d start %0d",
                              " len %0d line %0d end %0b"},
                             $time, expected_tokens[0].kind, expected_tokens[0].start,
                             expected_tokens[0].length, expected_tokens[0].line,
                             expected_tokens[0].run_end);
                    $display({"%0t                   actual kind %0d start %0d",
                              " len %0d line %0d end %0b"},
                             $time, token_kind, token_start, token_length, line_number,
                             run_end);
                    errors <= errors + 1;
                end
                void'(expected_tokens.pop_front());
            end
            stall_left = calm ? 0 : $urandom_range(0, 8);
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= 1'b1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int k;
        first_line = pts_pkg::FIRST_LINE_RESET;
        start_over();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_byte(directed[i].b, directed[i].fin, k);
            if (k != directed[i].want)
            begin
                $display("%0t row %0d: expected kind %0d, predicted %0d", $time, i,
                         directed[i].want, k);
                errors++;
            end
        end

        // long word: length saturation and no keyword match past the prefix
        set_first_line(16'hFFFF);
        calm = 1'b1;
        send_text("procedurex procedure ");
        for (int i = 0; i < 260; i++) send_byte("a", 1'b0, k);
        send_byte(pts_pkg::CH_LF, 1'b0, k);
        send_byte(pts_pkg::CH_SEMI, 1'b1, k);
        calm = 1'b0;

        set_first_line(16'd0);
        idle_input();
        apb_access(1'b1, ADDR_UNUSED, 32'hFFFF_FFFF);   // ignored register
        random_text(items_sent + 30);
        set_first_line(16'hFFFE);
        send_text("\n\n\n;");
        random_text(items_sent + 30);
        calm = 1'b1;
        random_text(items_sent + 20);
        calm = 1'b0;
        set_first_line(16'($urandom()));
        random_text(ITEM_TARGET);
        send_byte(pts_pkg::CH_SPACE, 1'b1, k);

        idle_input();
        $display("Sent %0d bytes in %0d sources, checked %0d tokens over %0d cycles.",
                 items_sent, sources_done, tokens_seen, cycles);
        if (errors == 0 && expected_tokens.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

FILE: pascal_token_scanner.f
sv/pts_pkg.sv
sv/pts_lexer.sv
sv/pts_queue.sv
sv/pascal_token_scanner.sv
sv/pts_checker.sv
bench/testbench.sv
